>>> sv/kpsd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the keypad scan, debounce and colour block.
// No dependencies; used by kpsd_row_lane and keypad_scan_debounce_color_core.
package kpsd_pkg;

  // Fixed field widths of the stream payloads and the register.
  localparam int COLUMN_W  = 2;
  localparam int LEVEL_W   = 4;
  localparam int MASK_W    = 16;
  localparam int ROW_OUT_W = 4;
  localparam int CNT_W     = 4;
  localparam int COLOR_W   = 2;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CNT_W-1:0] LIMIT_RESET = 4'd4;

  // LED colour codes; a press steps a key through them in this order.
  localparam logic [COLOR_W-1:0] COLOR_OFF   = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_RED   = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_GREEN = 2'd2;
  localparam logic [COLOR_W-1:0] COLOR_BLUE  = 2'd3;

  // What one row lane reports for the column being processed.
  typedef struct packed {
    logic               press;
    logic [COLOR_W-1:0] color;
  } lane_res_t;

endpackage

>>> sv/kpsd_row_lane.sv
`timescale 1ns / 1ps
// One row of the key matrix: debounce counters, colours and pressed bits
// for every column of that row. Depends on kpsd_pkg.
module kpsd_row_lane #(
  parameter int COLUMNS = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           update,
  input  logic [kpsd_pkg::COLUMN_W-1:0]  column,
  input  logic                           low,
  input  logic [kpsd_pkg::CNT_W-1:0]     limit,
  output kpsd_pkg::lane_res_t            res,
  output logic [COLUMNS-1:0]             pressed_next
);

  logic [kpsd_pkg::CNT_W-1:0]   cnt   [COLUMNS];
  logic [kpsd_pkg::COLOR_W-1:0] color [COLUMNS];
  logic [COLUMNS-1:0]           pressed;
  logic [COLUMNS-1:0]           sel;

  logic [kpsd_pkg::CNT_W-1:0]   cnt_rd;
  logic [kpsd_pkg::COLOR_W-1:0] color_rd;
  logic [kpsd_pkg::CNT_W-1:0]   cnt_next;
  logic [kpsd_pkg::COLOR_W-1:0] color_next;
  logic [kpsd_pkg::CNT_W-1:0]   limit_eff;
  logic                         set_key;
  logic                         clr_key;
  logic                         press;

  for (genvar c = 0; c < COLUMNS; c++) begin : g_sel
    assign sel[c] = (32'(column) == 32'(c));
  end

  always_comb begin
    cnt_rd   = '0;
    color_rd = kpsd_pkg::COLOR_OFF;
    for (int c = 0; c < COLUMNS; c++) begin
      if (sel[c]) begin
        cnt_rd   = cnt[c];
        color_rd = color[c];
      end
    end
  end

  // A limit of zero behaves as a limit of one.
  assign limit_eff = (limit == '0) ? kpsd_pkg::CNT_W'(1) : limit;

  always_comb begin
    cnt_next   = cnt_rd;
    color_next = color_rd;
    set_key    = 1'b0;
    clr_key    = 1'b0;
    press      = 1'b0;
    if (low) begin
      if (cnt_rd < limit_eff) begin
        cnt_next = cnt_rd + 1'b1;
        if (cnt_next == limit_eff) begin
          set_key    = 1'b1;
          press      = 1'b1;
          color_next = color_rd + 1'b1;
        end
      end else begin
        // Held at or beyond the limit: stays pressed, no new event.
        set_key = 1'b1;
      end
    end else begin
      if (cnt_rd == '0) begin
        clr_key    = 1'b1;
        color_next = kpsd_pkg::COLOR_OFF;
      end else begin
        cnt_next = cnt_rd - 1'b1;
      end
    end
  end

  assign pressed_next = set_key ? (pressed | sel)
                      : clr_key ? (pressed & ~sel)
                      : pressed;

  assign res.press = press;
  assign res.color = color_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed <= '0;
      for (int c = 0; c < COLUMNS; c++) begin
        cnt[c]   <= '0;
        color[c] <= kpsd_pkg::COLOR_OFF;
      end
    end else if (update) begin
      pressed <= pressed_next;
      for (int c = 0; c < COLUMNS; c++) begin
        if (sel[c]) begin
          cnt[c]   <= cnt_next;
          color[c] <= color_next;
        end
      end
    end
  end

endmodule

>>> sv/keypad_scan_debounce_color_core.sv
`timescale 1ns / 1ps
// Top level of the keypad matrix scanner with per-key debounce and LED colours.
// Depends on kpsd_pkg and kpsd_row_lane (one lane per matrix row).
//
//  Channel | Direction | Handshake       | Payload
//  s_axis  | in        | tvalid / tready | tdata: column[1:0], rows_level[5:2]
//  m_axis  | out       | tvalid / tready | tdata: pressed_mask, press_events, R, G, B
//  cfg     | in        | cfg_we          | cfg_wdata: debounce_limit
//
// One transfer in and one transfer out per cycle when both sides flow; a scan
// is held in the input register and then captured in the output register.
// The key state is read and written back within that single pass. Reset
// clears all counters, colours, pressed bits and both stages, and loads a
// debounce limit of four. A stalled output holds its result, and the input
// stage keeps accepting while empty.
module keypad_scan_debounce_color_core #(
  parameter int ROWS    = 4,
  parameter int COLUMNS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [kpsd_pkg::CNT_W-1:0]          cfg_wdata,   // debounce_limit
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // column [1:0], rows_level [5:2], zero [7:6]
  input  logic [kpsd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // pressed_mask [15:0], press_events [19:16], led_red [23:20],
  // led_green [27:24], led_blue [31:28]
  output logic [kpsd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int NKEYS = ROWS * COLUMNS;

  logic [kpsd_pkg::CNT_W-1:0]     limit;
  logic                           in_valid;
  logic [kpsd_pkg::COLUMN_W-1:0]  in_col;
  logic [kpsd_pkg::LEVEL_W-1:0]   in_levels;
  logic                           out_valid;
  logic [kpsd_pkg::MASK_W-1:0]    out_mask;
  logic [kpsd_pkg::ROW_OUT_W-1:0] out_events;
  logic [kpsd_pkg::ROW_OUT_W-1:0] out_red;
  logic [kpsd_pkg::ROW_OUT_W-1:0] out_green;
  logic [kpsd_pkg::ROW_OUT_W-1:0] out_blue;

  logic                           s_accept;
  logic                           advance;
  logic                           in_range;

  kpsd_pkg::lane_res_t            lane_res [ROWS];
  logic [COLUMNS-1:0]             lane_pressed [ROWS];
  logic [ROWS-1:0]                evt_all;
  logic [ROWS-1:0]                red_all;
  logic [ROWS-1:0]                green_all;
  logic [ROWS-1:0]                blue_all;
  logic [NKEYS-1:0]               keys_next;
  logic [kpsd_pkg::MASK_W-1:0]    mask_next;
  logic [kpsd_pkg::ROW_OUT_W-1:0] evt_next;
  logic [kpsd_pkg::ROW_OUT_W-1:0] red_next;
  logic [kpsd_pkg::ROW_OUT_W-1:0] green_next;
  logic [kpsd_pkg::ROW_OUT_W-1:0] blue_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_range      = (32'(in_col) < 32'(COLUMNS));

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    logic low;

    // Rows beyond the level field read as released.
    if (r < kpsd_pkg::LEVEL_W) begin : g_lvl
      assign low = ~in_levels[r];
    end else begin : g_nolvl
      assign low = 1'b0;
    end

    kpsd_row_lane #(
      .COLUMNS (COLUMNS)
    ) u_lane (
      .clk          (clk),
      .rst          (rst),
      .update       (advance && in_range),
      .column       (in_col),
      .low          (low),
      .limit        (limit),
      .res          (lane_res[r]),
      .pressed_next (lane_pressed[r])
    );

    always_comb begin
      evt_all[r]   = lane_res[r].press;
      red_all[r]   = 1'b0;
      green_all[r] = 1'b0;
      blue_all[r]  = 1'b0;
      case (lane_res[r].color)
        kpsd_pkg::COLOR_RED:   red_all[r]   = 1'b1;
        kpsd_pkg::COLOR_GREEN: green_all[r] = 1'b1;
        kpsd_pkg::COLOR_BLUE:  blue_all[r]  = 1'b1;
        default: ;
      endcase
    end

    for (genvar c = 0; c < COLUMNS; c++) begin : g_key
      assign keys_next[c*ROWS + r] = lane_pressed[r][c];
    end
  end

  for (genvar i = 0; i < kpsd_pkg::ROW_OUT_W; i++) begin : g_rowout
    if (i < ROWS) begin : g_on
      assign evt_next[i]   = in_range & evt_all[i];
      assign red_next[i]   = in_range & red_all[i];
      assign green_next[i] = in_range & green_all[i];
      assign blue_next[i]  = in_range & blue_all[i];
    end else begin : g_off
      assign evt_next[i]   = 1'b0;
      assign red_next[i]   = 1'b0;
      assign green_next[i] = 1'b0;
      assign blue_next[i]  = 1'b0;
    end
  end

  for (genvar k = 0; k < kpsd_pkg::MASK_W; k++) begin : g_mask
    if (k < NKEYS) begin : g_on
      assign mask_next[k] = keys_next[k];
    end else begin : g_off
      assign mask_next[k] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit     <= kpsd_pkg::LIMIT_RESET;
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (s_accept) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      in_col    <= s_axis_tdata[kpsd_pkg::COLUMN_W-1:0];
      in_levels <= s_axis_tdata[kpsd_pkg::COLUMN_W +: kpsd_pkg::LEVEL_W];
    end
    if (advance) begin
      out_mask   <= mask_next;
      out_events <= evt_next;
      out_red    <= red_next;
      out_green  <= green_next;
      out_blue   <= blue_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_blue, out_green, out_red, out_events, out_mask};

  // At most one colour lights per row.
  a_led_onehot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((out_red & out_green) | (out_red & out_blue)
                       | (out_green & out_blue)) == '0)
    else $error("more than one LED colour driven on a row");

  // The input side only stalls when both stages are full and the output waits.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (in_valid && out_valid && !m_axis_tready))
    else $error("input stalled without a blocked output");

  // A scan held in the input register is never dropped.
  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("pending scan lost from the input register");

  // Nothing is offered straight after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result offered right after reset");

endmodule
